@@ rtl/core/flac_pkg.sv @@
// Shared constants and types for the fully associative LRU tag store.
// Used by the cell, hit encoder and top-level modules; no dependencies.
package flac_pkg;

  localparam int LINES  = 256;
  localparam int IDX_W  = $clog2(LINES);
  localparam int ADDR_W = 64;
  localparam int CNT_W  = 32;
  localparam int OFS_W  = 4;

  localparam logic [OFS_W-1:0] OFFSET_MAX   = 4'd12;
  localparam logic [OFS_W-1:0] OFFSET_RESET = 4'd3;
  localparam logic [CNT_W-1:0] COUNT_MAX    = '1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] block;
    logic              valid;
    logic              dirty;
  } line_t;

  typedef struct packed {
    logic             cmp_en;
    logic             upd_en;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
  } cell_ctl_t;

endpackage

@@ rtl/core/flac_cell.sv @@
// One line of the recency-ordered tag list: holds a block, valid and dirty bit.
// Compares against the search key and loads from its upper neighbor on a shift.
// Depends on flac_pkg.
module flac_cell
  import flac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  cell_idx,
  input  logic [ADDR_W-1:0] key,
  input  cell_ctl_t         ctl,
  input  line_t             prev,
  output line_t             line,
  output logic              match,
  output logic              match_dirty
);

  logic [ADDR_W-1:0] block_r;
  logic              valid_r;
  logic              dirty_r;
  logic              match_r;
  logic              load;

  // A line takes its neighbor's entry when it lies at or above the stop point.
  assign load = ctl.upd_en && prev.valid && !(ctl.hit && (ctl.hit_idx < cell_idx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        match_r <= valid_r && (block_r == key);
      end
      if (load) begin
        valid_r <= prev.valid;
        dirty_r <= prev.dirty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      block_r <= prev.block;
    end
  end

  assign line        = '{block: block_r, valid: valid_r, dirty: dirty_r};
  assign match       = match_r;
  assign match_dirty = match_r && dirty_r;

endmodule

@@ rtl/core/flac_hit_enc.sv @@
// Reduces the per-line match flags to a hit flag, the hit line index and its dirty bit.
// The match vector is one-hot or zero. Depends on flac_pkg.
module flac_hit_enc
  import flac_pkg::*;
(
  input  logic [LINES-1:0] match,
  input  logic [LINES-1:0] match_dirty,
  output logic             hit,
  output logic [IDX_W-1:0] hit_idx,
  output logic             keep_dirty
);

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < LINES; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit        = |match;
  assign keep_dirty = |match_dirty;

endmodule

@@ rtl/core/fully_assoc_lru_cache_tags.sv @@
// Tag store of a fully associative cache with LRU replacement, built as a chain
// of line cells. Depends on flac_pkg, flac_cell and flac_hit_enc.
//
// Usage: an access beat (in_op, in_address) is taken on in_valid && in_ready.
// The block number is the address shifted right by the block offset register
// (cfg_we/cfg_data, values above 12 act as 12, reset value 3).
// In the compare state, every cell compares its block against the key.
// In the update state, the hit index is encoded and the list shifts down by one
// step toward the hit line or the free line (the last line drops out if none is
// free), and the new entry enters line 0. The result beat (out_hit, out_hit_count,
// out_access_count) is registered when the update state completes. An access
// passes the compare stage and the shift stage of the cell chain; a new beat is
// taken in the shift state. If the output is stalled, the shift stage waits until
// the held result is taken, and the input stays not ready meanwhile.
// Reset invalidates every line, clears both counters and the output valid flag.
module fully_assoc_lru_cache_tags
  import flac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [OFS_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [CNT_W-1:0]  out_hit_count,
  output logic [CNT_W-1:0]  out_access_count
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [OFS_W-1:0]  ofs_r;
  logic [OFS_W-1:0]  ofs_eff;
  logic [ADDR_W-1:0] key_r;
  logic              op_r;
  logic              out_valid_r;
  logic              out_hit_r;
  logic [CNT_W-1:0]  hits_r;
  logic [CNT_W-1:0]  accesses_r;
  logic              upd_go;
  logic              accept;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              keep_dirty;
  logic              new_dirty;
  cell_ctl_t         ctl;
  line_t             lines    [LINES];
  line_t             prev_line[LINES];
  logic [LINES-1:0]  match;
  logic [LINES-1:0]  match_dirty;

  assign upd_go   = (state_r == ST_UPD) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE) || upd_go;
  assign accept   = in_valid && in_ready;
  assign ofs_eff  = (ofs_r > OFFSET_MAX) ? OFFSET_MAX : ofs_r;
  assign new_dirty = keep_dirty || (op_r == OP_WRITE);

  assign ctl = '{cmp_en: (state_r == ST_CMP), upd_en: upd_go, hit: hit, hit_idx: hit_idx};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (upd_go) begin
          state_nxt = accept ? ST_CMP : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ofs_r       <= OFFSET_RESET;
      out_valid_r <= 1'b0;
      hits_r      <= '0;
      accesses_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        ofs_r <= cfg_data;
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
        if (hit && (hits_r != COUNT_MAX)) begin
          hits_r <= hits_r + 1'b1;
        end
        if (accesses_r != COUNT_MAX) begin
          accesses_r <= accesses_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_address >> ofs_eff;
      op_r  <= in_op;
    end
    if (upd_go) begin
      out_hit_r <= hit;
    end
  end

  assign prev_line[0] = '{block: key_r, valid: 1'b1, dirty: new_dirty};

  for (genvar g = 0; g < LINES; g++) begin : g_cell
    if (g > 0) begin : g_link
      assign prev_line[g] = lines[g-1];
    end
    flac_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (IDX_W'(g)),
      .key         (key_r),
      .ctl         (ctl),
      .prev        (prev_line[g]),
      .line        (lines[g]),
      .match       (match[g]),
      .match_dirty (match_dirty[g])
    );
  end

  flac_hit_enc u_enc (
    .match       (match),
    .match_dirty (match_dirty),
    .hit         (hit),
    .hit_idx     (hit_idx),
    .keep_dirty  (keep_dirty)
  );

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_count    = hits_r;
  assign out_access_count = accesses_r;

endmodule
